/* hw/rtl/prbs_pkg.sv */
// Shared types, register indexes and the feedback tap table for the PRBS generator.
`default_nettype none
package prbs_pkg;

  localparam int ORDER_W   = 5;
  localparam int SEED_W    = 31;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 31;
  localparam int TAP_W     = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORDER  = 2'd0,
    CFG_SEED   = 2'd1,
    CFG_INVERT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic load;
    logic update;
    logic shift;
  } cell_ctrl_t;

  localparam logic [TAP_W-1:0] TAP_TABLE [32] = '{
    31'h0, 31'h0,
    31'h3, 31'h5, 31'h9, 31'h9, 31'h21, 31'h41, 31'h71, 31'h21,
    31'h281, 31'h201, 31'h941, 31'h1601, 31'h2111, 31'h4001, 31'hD009,
    (31'h1 << 15) | 31'h1, (31'h1 << 16) | 31'h1, (31'h1 << 17) | 31'h1,
    (31'h1 << 18) | 31'h1, (31'h1 << 19) | 31'h1, (31'h1 << 20) | 31'h1,
    (31'h1 << 21) | 31'h1, (31'h1 << 22) | 31'h1, (31'h1 << 23) | 31'h1,
    (31'h1 << 24) | 31'h1, (31'h1 << 25) | 31'h1, (31'h1 << 26) | 31'h1,
    (31'h1 << 27) | 31'h1, (31'h1 << 28) | 31'h1, (31'h1 << 29) | 31'h1
  };

endpackage
`default_nettype wire

/* hw/rtl/prbs_cell.sv */
// One bit of the shift register: seed load, masking, shift from the lower neighbor.
`default_nettype none
module prbs_cell (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  init_bit,
  input  wire prbs_pkg::cell_ctrl_t  ctrl,
  input  wire logic                  active,
  input  wire logic                  tap,
  input  wire logic                  seed_bit,
  input  wire logic                  shift_in,
  output logic                       eff_out,
  output logic                       tap_out
);

  logic bit_r;
  logic bit_nxt;

  assign eff_out = (ctrl.load ? seed_bit : bit_r) & active;
  assign tap_out = eff_out & tap;

  always_comb begin
    bit_nxt = bit_r;
    if (ctrl.update) begin
      if (ctrl.shift) begin
        bit_nxt = shift_in & active;
      end else if (ctrl.load) begin
        bit_nxt = eff_out;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= init_bit;
    end else begin
      bit_r <= bit_nxt;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/prbs_period_cnt.sv */
// Period counter: counts advancing ticks and flags the end of each sequence period.
`default_nettype none
module prbs_period_cnt #(
  parameter int W = 31
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire prbs_pkg::cell_ctrl_t  ctrl,
  input  wire logic [W-1:0]          period,
  output logic                       period_end,
  output logic [W-1:0]               count
);

  logic [W-1:0] cnt_r;
  logic [W-1:0] cnt_nxt;
  logic [W-1:0] base;
  logic [W:0]   inc;

  assign base       = ctrl.load ? '0 : cnt_r;
  assign inc        = {1'b0, base} + {{W{1'b0}}, 1'b1};
  assign period_end = ctrl.shift && (inc >= {1'b0, period});
  assign count      = cnt_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctrl.update) begin
      if (!ctrl.shift) begin
        cnt_nxt = base;
      end else if (period_end) begin
        cnt_nxt = '0;
      end else begin
        cnt_nxt = inc[W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/prbs_lfsr_generator.sv */
// Fibonacci LFSR PRBS generator, order 2..MAX_ORDER, one bit per transaction.
// The feedback is one XOR reduction over the cell row; each result is registered on acceptance.
// Throughput: one transaction per cycle, unless a held result waits on out_ready.
// Reset (synchronous, rst_n low): order 7, seed 1, no inversion, register 1, count 0,
// output register empty.
`default_nettype none
module prbs_lfsr_generator #(
  parameter int MAX_ORDER = 31
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_restart,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_bit,
  output logic                                out_period_end,
  output logic                                out_seed_error,
  input  wire logic                           cfg_we,
  input  wire logic [prbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [prbs_pkg::CFG_W-1:0]     cfg_data
);

  localparam int IDX_W = (MAX_ORDER > 2) ? $clog2(MAX_ORDER) : 1;

  logic [prbs_pkg::ORDER_W-1:0] order_r;
  logic [MAX_ORDER-1:0]         seed_r;
  logic                         invert_r;

  logic [prbs_pkg::ORDER_W-1:0] ord_eff;
  logic [IDX_W-1:0]             top_idx;
  logic [MAX_ORDER-1:0]         active_vec;
  logic [MAX_ORDER-1:0]         tap_vec;
  logic [MAX_ORDER-1:0]         eff_vec;
  logic [MAX_ORDER-1:0]         tap_out_vec;
  logic [MAX_ORDER-1:0]         shift_in_vec;
  logic [prbs_pkg::TAP_W-1:0]   tap_row;
  logic [MAX_ORDER-1:0]         cnt;
  logic                         fb;
  logic                         nonzero;
  logic                         in_fire;
  logic                         pend;
  prbs_pkg::cell_ctrl_t         ctrl;

  logic out_valid_r,  out_valid_nxt;
  logic out_bit_r,    out_bit_nxt;
  logic out_pend_r,   out_pend_nxt;
  logic out_err_r,    out_err_nxt;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r  <= prbs_pkg::ORDER_W'(7);
      seed_r   <= MAX_ORDER'(1);
      invert_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        prbs_pkg::CFG_ORDER:  order_r  <= cfg_data[prbs_pkg::ORDER_W-1:0];
        prbs_pkg::CFG_SEED:   seed_r   <= cfg_data[MAX_ORDER-1:0];
        prbs_pkg::CFG_INVERT: invert_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ord_eff = order_r;
    if (order_r < prbs_pkg::ORDER_W'(2)) begin
      ord_eff = prbs_pkg::ORDER_W'(2);
    end else if (order_r > prbs_pkg::ORDER_W'(MAX_ORDER)) begin
      ord_eff = prbs_pkg::ORDER_W'(MAX_ORDER);
    end
  end

  assign top_idx = IDX_W'(ord_eff - prbs_pkg::ORDER_W'(1));
  assign tap_row = prbs_pkg::TAP_TABLE[ord_eff];
  assign tap_vec = tap_row[MAX_ORDER-1:0];

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign nonzero  = |eff_vec;
  assign fb       = ^tap_out_vec;

  assign ctrl.load   = in_restart;
  assign ctrl.update = in_fire;
  assign ctrl.shift  = nonzero;

  assign shift_in_vec = {eff_vec[MAX_ORDER-2:0], fb};

  for (genvar i = 0; i < MAX_ORDER; i++) begin : g_cell
    assign active_vec[i] = (prbs_pkg::ORDER_W'(i) < ord_eff);

    prbs_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .init_bit ((i == 0) ? 1'b1 : 1'b0),
      .ctrl     (ctrl),
      .active   (active_vec[i]),
      .tap      (tap_vec[i]),
      .seed_bit (seed_r[i]),
      .shift_in (shift_in_vec[i]),
      .eff_out  (eff_vec[i]),
      .tap_out  (tap_out_vec[i])
    );
  end

  prbs_period_cnt #(
    .W (MAX_ORDER)
  ) u_period_cnt (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .period     (active_vec),
    .period_end (pend),
    .count      (cnt)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_bit_nxt   = out_bit_r;
    out_pend_nxt  = out_pend_r;
    out_err_nxt   = out_err_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
      out_bit_nxt   = nonzero && (eff_vec[top_idx] ^ invert_r);
      out_pend_nxt  = pend;
      out_err_nxt   = !nonzero;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_bit_r  <= out_bit_nxt;
    out_pend_r <= out_pend_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_bit        = out_bit_r;
  assign out_period_end = out_pend_r;
  assign out_seed_error = out_err_r;

`ifndef SYNTHESIS
  a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_seed_error |-> !out_bit && !out_period_end)
    else $error("seed error result carries data");

  a_fire_flags: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid && (out_seed_error == !$past(nonzero)))
    else $error("result flags do not follow accepted transaction");

  a_pend_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && pend |=> cnt == '0)
    else $error("period count not cleared at period end");

  a_zero_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !nonzero |=> cnt == '0 || $stable(cnt))
    else $error("period count moved on all-zero register");
`endif

endmodule
`default_nettype wire
